/* rtl/pr_pkg.sv */
package pr_pkg;

    // Field and register widths
    localparam int DATA_WIDTH      = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int MODE_WIDTH      = 2;
    localparam int MULT_WIDTH      = 16;
    localparam int SHIFT_WIDTH     = 6;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Average datapath widths
    localparam int PROD_WIDTH = DATA_WIDTH + MULT_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH + 1;
    localparam int EXT_WIDTH  = (RND_WIDTH > OUT_WIDTH) ? RND_WIDTH : OUT_WIDTH;

    // Low DATA_WIDTH bits of a result word
    localparam logic [OUT_WIDTH-1:0] DATA_MASK =
        OUT_WIDTH'((65'd1 << DATA_WIDTH) - 65'd1);

    // Pooling modes
    localparam logic [MODE_WIDTH-1:0] MODE_MAX = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_MIN = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_AVG = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SUM = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POOL_MODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROUND     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MULT      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT     = 3'd3;

    // Reset value of the average multiplier
    localparam logic [MULT_WIDTH-1:0] MULT_RESET = 16'd1;

    typedef struct packed {
        logic [MODE_WIDTH-1:0]  mode;
        logic                   rnd;
        logic [MULT_WIDTH-1:0]  mult;
        logic [SHIFT_WIDTH-1:0] shift;
    } t_cfg;

    // Completed window leaving the accumulator
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         avg;
    } t_win;

    // After the magnitude multiply
    typedef struct packed {
        logic [PROD_WIDTH-1:0]        prod;
        logic                         neg;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         avg;
    } t_prod;

    // After rounding and shift
    typedef struct packed {
        logic [RND_WIDTH-1:0]         mag;
        logic                         neg;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         avg;
    } t_shf;

endpackage

/* rtl/pr_in_if.sv */
interface pr_in_if import pr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    window_end;

    modport source (output valid, output sample, output window_end, input ready);
    modport sink   (input valid, input sample, input window_end, output ready);
endinterface

/* rtl/pr_out_if.sv */
interface pr_out_if import pr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] pooled;

    modport source (output valid, output pooled, input ready);
    modport sink   (input valid, input pooled, output ready);
endinterface

/* rtl/pr_cfg_if.sv */
interface pr_cfg_if import pr_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pr_regs.sv */
module pr_regs import pr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pr_cfg_if.sink i_cfg,
    output t_cfg   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always take a write; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POOL_MODE: n_cfg.mode  = i_cfg.data[MODE_WIDTH-1:0];
                REG_ROUND:     n_cfg.rnd   = i_cfg.data[0];
                REG_MULT:      n_cfg.mult  = i_cfg.data[MULT_WIDTH-1:0];
                REG_SHIFT:     n_cfg.shift = i_cfg.data[SHIFT_WIDTH-1:0];
                default:       n_cfg       = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_MAX;
            r_cfg.rnd   <= 1'b0;
            r_cfg.mult  <= MULT_RESET;
            r_cfg.shift <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/pr_accum.sv */
module pr_accum import pr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    pr_in_if.sink  i_in,
    output logic   o_valid,
    input  logic   i_ready,
    output t_win   o_win
);

    logic signed [DATA_WIDTH-1:0] r_run;
    logic signed [DATA_WIDTH-1:0] n_run;
    logic                         r_start;
    logic                         r_vld;
    t_win                         r_win;
    logic signed [DATA_WIDTH-1:0] x;
    logic                         acc;

    // Take a new sample whenever the window slot is free or draining
    assign i_in.ready = !r_vld || i_ready;
    assign acc        = i_in.valid && i_in.ready;
    assign x          = i_in.sample[DATA_WIDTH-1:0];

    // Fold the sample into the running value
    always_comb begin
        if (r_start) begin
            n_run = x;
        end else begin
            case (i_cfg.mode)
                MODE_MAX: n_run = (x > r_run) ? x : r_run;
                MODE_MIN: n_run = (x < r_run) ? x : r_run;
                default:  n_run = r_run + x;
            endcase
        end
    end

    // Advance the running state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_start <= 1'b1;
        end else if (acc) begin
            r_run   <= n_run;
            r_start <= i_in.window_end;
        end
    end

    // Hold the finished window until the next stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc && i_in.window_end) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_in.window_end) begin
            r_win.value <= n_run;
            r_win.avg   <= (i_cfg.mode == MODE_AVG);
        end
    end

    assign o_valid = r_vld;
    assign o_win   = r_win;

    a_reset_opens_window: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_start && !r_vld))
        else $error("window not reopened after reset");

    a_max_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_start && i_cfg.mode == MODE_MAX) |=> (r_run >= $past(r_run)))
        else $error("running maximum decreased");

    a_min_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_start && i_cfg.mode == MODE_MIN) |=> (r_run <= $past(r_run)))
        else $error("running minimum increased");

endmodule

/* rtl/pr_scale.sv */
module pr_scale import pr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_win   i_win,
    output logic   o_valid,
    input  logic   i_ready,
    output t_shf   o_shf
);

    logic                  r_b_vld;
    t_prod                 r_b;
    logic                  r_c_vld;
    t_shf                  r_c;
    logic                  b_ready;
    logic                  c_ready;
    logic                  neg;
    logic [DATA_WIDTH-1:0] mag;
    logic [RND_WIDTH-1:0]  rnd_add;
    logic [RND_WIDTH-1:0]  rnd_sum;

    assign c_ready = !r_c_vld || i_ready;
    assign b_ready = !r_b_vld || c_ready;
    assign o_ready = b_ready;

    // Magnitude of the window value times the multiplier
    assign neg = i_win.value[DATA_WIDTH-1];
    assign mag = neg ? (~i_win.value + 1'b1) : i_win.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_ready) begin
            r_b_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && i_valid) begin
            r_b.prod  <= PROD_WIDTH'(mag) * PROD_WIDTH'(i_cfg.mult);
            r_b.neg   <= neg;
            r_b.value <= i_win.value;
            r_b.avg   <= i_win.avg;
        end
    end

    // Add half an LSB when rounding, then shift the magnitude down
    always_comb begin
        rnd_add = '0;
        if (i_cfg.rnd && (i_cfg.shift != '0)) begin
            rnd_add = RND_WIDTH'(1) << (i_cfg.shift - 1'b1);
        end
        rnd_sum = {1'b0, r_b.prod} + rnd_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (c_ready) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_vld) begin
            r_c.mag   <= rnd_sum >> i_cfg.shift;
            r_c.neg   <= r_b.neg;
            r_c.value <= r_b.value;
            r_c.avg   <= r_b.avg;
        end
    end

    assign o_valid = r_c_vld;
    assign o_shf   = r_c;

endmodule

/* rtl/pr_out.sv */
module pr_out import pr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_shf     i_shf,
    pr_out_if.source o_out
);

    logic                 r_vld;
    logic [OUT_WIDTH-1:0] r_out;
    logic [EXT_WIDTH-1:0] ext;
    logic [EXT_WIDTH-1:0] ext_neg;
    logic [OUT_WIDTH-1:0] word;
    logic [OUT_WIDTH-1:0] n_out;

    assign o_ready = !r_vld || o_out.ready;

    // Restore the sign, wrap to the result width, then cut to the data width
    always_comb begin
        ext     = EXT_WIDTH'(i_shf.mag);
        ext_neg = ~ext + 1'b1;
        if (i_shf.avg) begin
            word = i_shf.neg ? ext_neg[OUT_WIDTH-1:0] : ext[OUT_WIDTH-1:0];
        end else begin
            word = OUT_WIDTH'(i_shf.value);
        end
        n_out = word[OUT_WIDTH-1] ? (word | ~DATA_MASK) : (word & DATA_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid  = r_vld;
    assign o_out.pooled = r_out;

    a_result_sign_extended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ((r_out[OUT_WIDTH-1] && ((r_out | DATA_MASK) == '1)) ||
                   (!r_out[OUT_WIDTH-1] && ((r_out & ~DATA_MASK) == '0))))
        else $error("result not sign extended from the data width");

endmodule

/* rtl/pooling_reducer.sv */
// Channel   Dir  Fields               Transfer
// i_in      in   sample, window_end   i_in.valid && i_in.ready
// o_out     out  pooled               o_out.valid && o_out.ready
// i_cfg     in   index, data          i_cfg.valid && i_cfg.ready (always ready)
//
// One sample is taken every cycle unless a finished window is held by a stall;
// the running max/min/sum is a single register. A window result passes the
// accumulate, multiply, round/shift and output registers; the stages stream back to back.
// Reset (synchronous, active low) clears the valid bits, opens a new window
// and loads the register defaults. A stalled output holds its stage and the
// stall backs up stage by stage; an empty stage keeps accepting.
module pooling_reducer import pr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pr_in_if.sink    i_in,
    pr_out_if.source o_out,
    pr_cfg_if.sink   i_cfg
);

    t_cfg cfg;
    logic win_valid;
    logic win_ready;
    t_win win;
    logic shf_valid;
    logic shf_ready;
    t_shf shf;

    pr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pr_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_win   (win)
    );

    pr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_win   (win),
        .o_valid (shf_valid),
        .i_ready (shf_ready),
        .o_shf   (shf)
    );

    pr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (shf_valid),
        .o_ready (shf_ready),
        .i_shf   (shf),
        .o_out   (o_out)
    );

endmodule

/* test/pooling_reducer_checker.sv */
module pooling_reducer_checker import pr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pr_in_if     i_in,
    pr_out_if    i_out,
    pr_cfg_if    i_cfg,
    output int   o_error_count,
    output int   o_pending,
    output int   o_checked
);

    // Register copy as seen on the configuration channel
    logic [MODE_WIDTH-1:0]  cur_mode;
    logic                   cur_round;
    logic [MULT_WIDTH-1:0]  cur_mult;
    logic [SHIFT_WIDTH-1:0] cur_shift;

    // Window accumulator copy
    logic [OUT_WIDTH-1:0] run_value;
    logic                 opens_window;

    // Pooled values still owed by the block, oldest first
    logic [OUT_WIDTH-1:0] pooled_q[$];
    logic [OUT_WIDTH-1:0] new_pooled;
    logic [OUT_WIDTH-1:0] want_pooled;

    // Keep the low DATA_WIDTH bits, read as two's complement
    function automatic logic [OUT_WIDTH-1:0] sign_fill(input logic [OUT_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] d;
        d = v[DATA_WIDTH-1:0];
        return OUT_WIDTH'(d);
    endfunction

    // Scale the window sum: magnitude times factor, shift, restore the sign
    function automatic logic [OUT_WIDTH-1:0] scale_average(input logic [OUT_WIDTH-1:0] sum);
        longint      s;
        logic        neg;
        logic [63:0] mag;
        int unsigned sh;
        s   = longint'(signed'(sum));
        neg = (s < 0);
        mag = $unsigned(neg ? -s : s) * 64'(cur_mult);
        sh  = cur_shift;
        if (cur_round && sh > 0) begin
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
        end else begin
            mag = mag >> sh;
        end
        if (neg) begin
            mag = -mag;
        end
        return mag[OUT_WIDTH-1:0];
    endfunction

    // Set or clear the bits above DATA_WIDTH after the sign of the word
    function automatic logic [OUT_WIDTH-1:0] cut_to_width(input logic [OUT_WIDTH-1:0] v);
        return v[OUT_WIDTH-1] ? (v | ~DATA_MASK) : (v & DATA_MASK);
    endfunction

    // Fold one sample into the window; return 1 when it closes the window
    function automatic bit fold_sample(input logic [SAMPLE_WIDTH-1:0] raw, input logic last,
                                       output logic [OUT_WIDTH-1:0] pooled);
        logic [OUT_WIDTH-1:0] x;
        logic [OUT_WIDTH-1:0] r;
        x = sign_fill(OUT_WIDTH'(raw));
        pooled = '0;
        if (opens_window) begin
            run_value = x;
        end else begin
            case (cur_mode)
                MODE_MAX: begin
                    if (signed'(x) > signed'(run_value)) run_value = x;
                end
                MODE_MIN: begin
                    if (signed'(x) < signed'(run_value)) run_value = x;
                end
                default: begin
                    run_value = sign_fill(run_value + x);
                end
            endcase
        end
        opens_window = last;
        if (!last) return 1'b0;
        r = run_value;
        if (cur_mode == MODE_AVG) r = scale_average(run_value);
        pooled = cut_to_width(r);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                   input logic [OUT_WIDTH-1:0] want);
        $display("%0t mismatch: %s, pooled got %h want %h", $time, what, got, want);
        o_error_count++;
    endtask

    // Track every transfer at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode     = MODE_MAX;
            cur_round    = 1'b0;
            cur_mult     = MULT_RESET;
            cur_shift    = '0;
            run_value    = '0;
            opens_window = 1'b1;
            pooled_q.delete();
        end else begin
            // Compare a result transfer with the oldest owed value
            if (i_out.valid && i_out.ready) begin
                if (pooled_q.size() == 0) begin
                    report_mismatch("result with nothing owed", i_out.pooled, 'x);
                end else begin
                    want_pooled = pooled_q.pop_front();
                    if (i_out.pooled !== want_pooled) begin
                        report_mismatch("wrong pooled value", i_out.pooled, want_pooled);
                    end
                    o_checked++;
                end
            end
            // Apply register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_POOL_MODE: cur_mode  = i_cfg.data[MODE_WIDTH-1:0];
                    REG_ROUND:     cur_round = i_cfg.data[0];
                    REG_MULT:      cur_mult  = i_cfg.data[MULT_WIDTH-1:0];
                    REG_SHIFT:     cur_shift = i_cfg.data[SHIFT_WIDTH-1:0];
                    default: ;
                endcase
            end
            // Fold accepted samples
            if (i_in.valid && i_in.ready) begin
                if (fold_sample(i_in.sample, i_in.window_end, new_pooled)) begin
                    pooled_q.push_back(new_pooled);
                end
            end
        end
        o_pending = pooled_q.size();
    end

endmodule

/* test/pooling_reducer_tb.sv */
module pooling_reducer_tb;
    import pr_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int QUIET_FROM  = 1000;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   sent_count;
    int   phase_count;
    int   error_count;
    int   pending;
    int   checked;

    pr_in_if  in_ch();
    pr_out_if out_ch();
    pr_cfg_if cfg_ch();

    pooling_reducer uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    pooling_reducer_checker pool_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_error_count(error_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #10 clk = ~clk;

    // Stall the result side in random bursts while idling is on
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Give up on a hung run
    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one sample and hold it until the transfer
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            repeat (gap) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        in_ch.valid      = 1'b1;
        in_ch.sample     = value;
        in_ch.window_end = last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drop the input, wait for every owed result, then let the pipeline drain
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Write all four registers; fill unused data bits with noise
    task automatic configure(input logic [MODE_WIDTH-1:0] mode, input logic rnd,
                             input logic [MULT_WIDTH-1:0] mult,
                             input logic [SHIFT_WIDTH-1:0] shift);
        wait_idle();
        write_reg(REG_POOL_MODE, (CFG_DATA_WIDTH'($urandom) << MODE_WIDTH) | CFG_DATA_WIDTH'(mode));
        write_reg(REG_ROUND, (CFG_DATA_WIDTH'($urandom) << 1) | CFG_DATA_WIDTH'(rnd));
        write_reg(REG_MULT, CFG_DATA_WIDTH'(mult));
        write_reg(REG_SHIFT, (CFG_DATA_WIDTH'($urandom) << SHIFT_WIDTH) | CFG_DATA_WIDTH'(shift));
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return SAMPLE_WIDTH'($urandom_range(0, 40)) - 32'd20;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // One register setting followed by a burst of windows
    task automatic run_phase();
        logic [MULT_WIDTH-1:0]  mult;
        logic [SHIFT_WIDTH-1:0] shift;
        int windows;
        int len;
        case ($urandom_range(0, 4))
            0:       mult = '0;
            1:       mult = '1;
            2:       mult = MULT_RESET;
            default: mult = MULT_WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       shift = '0;
            1:       shift = SHIFT_WIDTH'(47);
            2:       shift = SHIFT_WIDTH'($urandom_range(48, 63));
            default: shift = SHIFT_WIDTH'($urandom_range(1, 12));
        endcase
        configure(MODE_WIDTH'($urandom), 1'($urandom), mult, shift);
        if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SHIFT + CFG_INDEX_WIDTH'($urandom_range(1, 4)),
                      CFG_DATA_WIDTH'($urandom));
        end
        idle_on = (sent_count < QUIET_FROM) && ($urandom_range(0, 3) != 0);
        phase_count++;
        windows = $urandom_range(4, 24);
        repeat (windows) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
            for (int k = 1; k <= len; k++) begin
                send_sample(pick_sample(), k == len);
            end
        end
        // Leave a window open now and then so the next setting lands inside it
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_sample(pick_sample(), 1'b0);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        in_ch.valid      = 1'b0;
        in_ch.sample     = '0;
        in_ch.window_end = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: max, single-sample window and extremes
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'd5, 1'b1);

        // Minimum
        configure(MODE_MIN, 1'b0, MULT_RESET, '0);
        send_sample(32'd7, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);

        // Plain sum, wrapping both ways
        configure(MODE_SUM, 1'b0, MULT_RESET, '0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'd1, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);

        // Average: widest product, rounding against truncation, large shifts
        configure(MODE_AVG, 1'b0, '1, '0);
        send_sample(32'h8000_0000, 1'b1);
        configure(MODE_AVG, 1'b1, MULT_WIDTH'(3), SHIFT_WIDTH'(2));
        send_sample(-32'sd3, 1'b0);
        send_sample(-32'sd2, 1'b1);
        configure(MODE_AVG, 1'b0, MULT_WIDTH'(3), SHIFT_WIDTH'(2));
        send_sample(-32'sd3, 1'b0);
        send_sample(-32'sd2, 1'b1);
        configure(MODE_AVG, 1'b1, '1, SHIFT_WIDTH'(47));
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        configure(MODE_AVG, 1'b1, '1, '1);
        send_sample(32'h7FFF_FFFF, 1'b1);
        configure(MODE_AVG, 1'b0, '0, '0);
        send_sample(32'd12345, 1'b1);

        // Switch from max to sum in the middle of a window
        configure(MODE_MAX, 1'b0, MULT_RESET, '0);
        send_sample(32'd10, 1'b0);
        send_sample(32'd3, 1'b0);
        configure(MODE_SUM, 1'b0, MULT_RESET, '0);
        write_reg(REG_SHIFT + CFG_INDEX_WIDTH'(1), '1);
        send_sample(32'd4, 1'b1);

        // Random settings and windows until the item count is reached
        while (sent_count < ITEM_TARGET) run_phase();

        wait_idle();
        repeat (12) @(negedge clk);
        $display("Run covered %0d samples over %0d random settings plus directed cases,",
                 sent_count, phase_count);
        $display("with %0d pooled results checked in all four modes.", checked);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* pooling_reducer.f */
rtl/pr_pkg.sv
rtl/pr_in_if.sv
rtl/pr_out_if.sv
rtl/pr_cfg_if.sv
rtl/pr_regs.sv
rtl/pr_accum.sv
rtl/pr_scale.sv
rtl/pr_out.sv
rtl/pooling_reducer.sv
test/pooling_reducer_checker.sv
test/pooling_reducer_tb.sv
